### hdl/atce_pkg.sv
// Shared types and constants of the text console engine.
package atce_pkg;

  // Fixed field widths of the item ports.
  localparam int IDX_W  = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;

  // Byte codes and attribute values.
  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [7:0] ATTR_SGR0  = 8'h08;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] CHAR_ESC   = 8'h1B;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_LBRK  = 8'h5B;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SGR   = 8'h6D;
  localparam logic [7:0] CHAR_ERASE = 8'h4A;

  // Command codes of an input item.
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // One input item.
  typedef struct packed {
    logic             command;
    logic [7:0]       byte_in;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic [7:0]       attribute;
  } res_item_t;

  // Operations handed from the parser to the screen engine.
  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_READ    = 3'd1,
    OP_TEXT    = 3'd2,
    OP_NEWLINE = 3'd3,
    OP_ERASE   = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t         kind;
    logic [7:0]       byte_in;
    logic [IDX_W-1:0] cell_index;
    logic [7:0]       attr;
  } op_t;

endpackage

### hdl/atce_queue.sv
// Small register queue used between the console stages.
module atce_queue #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  item_t          slot_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt;
  logic [PW-1:0]  rd_r, rd_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == NW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = slot_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_item;
    end
  end

endmodule

### hdl/atce_front.sv
// Byte parser: escape sequences, SGR attribute handling and op classification.
module atce_front #(
  parameter int ESC_LIMIT = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  atce_pkg::in_item_t in_item,
  output atce_pkg::op_t      op_item
);

  import atce_pkg::*;

  localparam int KW = $clog2(ESC_LIMIT + 1);

  typedef enum logic [2:0] {
    PH_TEXT  = 3'b001,
    PH_ESC   = 3'b010,
    PH_PARAM = 3'b100
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [KW-1:0] count_r, count_nxt;
  logic [7:0]    value_r, value_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic [7:0]    b;
  logic [7:0]    digit_val;
  logic [11:0]   acc;
  logic          is_digit;
  op_kind_t      kind;

  // Colour index with bits 0 and 2 exchanged.
  function automatic logic [2:0] swap_colour(input logic [7:0] v);
    return {v[0], v[1], v[2]};
  endfunction

  // Apply one SGR parameter to an attribute.
  function automatic logic [7:0] apply_sgr(input logic [7:0] a, input logic [7:0] v);
    logic [7:0] r;
    r = a;
    case (v) inside
      8'd0:              r = ATTR_SGR0;
      8'd38:             r = {a[7:4], 4'h0};
      8'd48:             r = {4'h0, a[3:0]};
      [8'd30:8'd37]:     r = {a[7:4], 1'b0, swap_colour(v - 8'd30)};
      [8'd40:8'd47]:     r = {1'b0, swap_colour(v - 8'd40), a[3:0]};
      [8'd90:8'd97]:     r = {a[7:4], 1'b1, swap_colour(v - 8'd90)};
      [8'd100:8'd107]:   r = {1'b1, swap_colour(v - 8'd100), a[3:0]};
      default:           r = a;
    endcase
    return r;
  endfunction

  assign b         = in_item.byte_in;
  assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign digit_val = b - CHAR_ZERO;
  assign acc       = 12'(value_r) * 12'd10 + 12'(digit_val);

  // Parser state update and classification of the item.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    value_nxt = value_r;
    pend_nxt  = pend_r;
    attr_nxt  = attr_r;
    kind      = OP_NOP;
    if (in_item.command == CMD_READ) begin
      kind = OP_READ;
    end else if (b != 8'h00) begin
      case (phase_r)
        PH_ESC: begin
          if (b == CHAR_LBRK) begin
            phase_nxt = PH_PARAM;
            count_nxt = '0;
            value_nxt = '0;
            pend_nxt  = attr_r;
          end else begin
            phase_nxt = PH_TEXT;
          end
        end
        PH_PARAM: begin
          if (!is_digit && b != CHAR_SEMI) begin
            if (b == CHAR_SGR) begin
              attr_nxt = apply_sgr(pend_r, value_r);
            end else if (b == CHAR_ERASE) begin
              kind = OP_ERASE;
            end
            phase_nxt = PH_TEXT;
            count_nxt = '0;
            value_nxt = '0;
          end else if (count_r >= KW'(ESC_LIMIT)) begin
            // Sequence too long: abandon it.
            phase_nxt = PH_TEXT;
            count_nxt = '0;
            value_nxt = '0;
          end else begin
            count_nxt = count_r + 1'b1;
            if (is_digit) begin
              value_nxt = (acc > 12'd255) ? 8'hFF : acc[7:0];
            end else begin
              pend_nxt  = apply_sgr(pend_r, value_r);
              value_nxt = '0;
            end
          end
        end
        default: begin
          if (b == CHAR_ESC) begin
            phase_nxt = PH_ESC;
          end else if (b == CHAR_LF) begin
            kind = OP_NEWLINE;
          end else begin
            kind = OP_TEXT;
          end
        end
      endcase
    end
  end

  // The op carries the attribute as it stands after this item.
  always_comb begin
    op_item.kind       = kind;
    op_item.byte_in    = b;
    op_item.cell_index = in_item.cell_index;
    op_item.attr       = attr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      count_r <= '0;
      value_r <= '0;
      pend_r  <= ATTR_RESET;
      attr_r  <= ATTR_RESET;
    end else if (in_valid) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      value_r <= value_nxt;
      pend_r  <= pend_nxt;
      attr_r  <= attr_nxt;
    end
  end

endmodule

### hdl/atce_back.sv
// Screen engine: cursor, screen memory, scroll and blanking sequencer.
module atce_back #(
  parameter int COLUMNS = 80,
  parameter int LINES   = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  atce_pkg::op_t       op_item,
  input  logic                op_empty,
  output logic                op_pop,
  output atce_pkg::res_item_t res_item,
  output logic                res_push,
  input  logic                res_full,
  output logic                clearing
);

  import atce_pkg::*;

  localparam int CELLS     = COLUMNS * LINES;
  localparam int AW        = $clog2(CELLS);
  localparam int LW        = $clog2(CELLS + 1);
  localparam int RW        = $clog2(LINES);
  localparam int CW        = $clog2(COLUMNS + 1);
  localparam int LAST_BASE = COLUMNS * (LINES - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_BLANK  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          pend_r, pend_nxt;
  logic          hit_r, hit_nxt;
  op_t           op_r, op_nxt;
  logic [15:0]   rd_data_r;
  logic [15:0]   screen_r [CELLS];

  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [15:0]   wd;
  logic [LW-1:0] lin_cur;
  logic [LW-1:0] src;
  logic          wrap;

  assign clearing = (state_r == ST_CLEAR);
  assign lin_cur  = LW'(row_r) * LW'(COLUMNS) + LW'(col_r);
  assign src      = LW'(ptr_r) + LW'(COLUMNS + 1);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    pend_nxt  = pend_r;
    hit_nxt   = hit_r;
    op_nxt    = op_r;
    op_pop    = 1'b0;
    res_push  = 1'b0;
    we        = 1'b0;
    wa        = '0;
    wd        = '0;
    re        = 1'b0;
    ra        = '0;
    wrap      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        // Fill every cell with the reset blank.
        we      = 1'b1;
        wa      = ptr_r;
        wd      = {ATTR_RESET, BLANK_CHAR};
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == AW'(CELLS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!op_empty && !res_full) begin
          op_pop   = 1'b1;
          op_nxt   = op_item;
          pend_nxt = 1'b0;
          case (op_item.kind)
            OP_READ: begin
              hit_nxt   = 32'(op_item.cell_index) < 32'(CELLS);
              re        = hit_nxt;
              ra        = AW'(op_item.cell_index);
              state_nxt = ST_READ;
            end
            OP_TEXT, OP_NEWLINE: begin
              wrap      = (op_item.kind == OP_NEWLINE) || (col_r == CW'(COLUMNS));
              pend_nxt  = (op_item.kind == OP_TEXT);
              state_nxt = ST_FINISH;
              if (wrap) begin
                col_nxt = '0;
                if (row_r == RW'(LINES - 1)) begin
                  // Past the bottom line: scroll up first.
                  ptr_nxt   = '0;
                  re        = 1'b1;
                  ra        = AW'(COLUMNS);
                  state_nxt = ST_SCROLL;
                end else begin
                  row_nxt = row_r + 1'b1;
                end
              end
            end
            OP_ERASE: begin
              if (lin_cur < LW'(CELLS)) begin
                ptr_nxt   = lin_cur[AW-1:0];
                state_nxt = ST_BLANK;
              end else begin
                state_nxt = ST_FINISH;
              end
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_READ: begin
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SCROLL: begin
        // Each cycle moves one cell up a line and fetches the next source.
        we      = 1'b1;
        wa      = ptr_r;
        wd      = rd_data_r;
        re      = (src < LW'(CELLS));
        ra      = src[AW-1:0];
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == AW'(LAST_BASE - 1)) begin
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK: begin
        we      = 1'b1;
        wa      = ptr_r;
        wd      = {op_r.attr, BLANK_CHAR};
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == AW'(CELLS - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Write a pending character at the cursor, then report.
        if (pend_r) begin
          we      = 1'b1;
          wa      = lin_cur[AW-1:0];
          wd      = {op_r.attr, op_r.byte_in};
          col_nxt = col_r + 1'b1;
        end
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result item.
  always_comb begin
    res_item.cell_char  = '0;
    res_item.cell_attr  = '0;
    if (state_r == ST_READ && hit_r) begin
      res_item.cell_char = rd_data_r[7:0];
      res_item.cell_attr = rd_data_r[15:8];
    end
    res_item.cursor_row = ROW_W'(row_r);
    res_item.cursor_col = COL_W'(col_nxt);
    res_item.attribute  = op_r.attr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Latched op and read flag carry payload only.
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    hit_r <= hit_nxt;
  end

  // Screen memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      screen_r[wa] <= wd;
    end
    if (re) begin
      rd_data_r <= screen_r[ra];
    end
  end

endmodule

### hdl/ansi_text_console_engine.sv
// Top level of the text console engine: parser, op queue, screen engine, result queue.
//
// Each put item feeds one byte to a COLUMNS x LINES screen of character and
// attribute cells; each read item returns one cell. Every item gives one result
// with the cursor and current attribute after it. The parser takes one item per
// cycle while full is low, into a four-entry op queue; the screen engine behind
// it takes a read through ST_READ, and a plain character, a newline without
// scroll or an escape byte straight to ST_FINISH. A scroll walks the whole
// screen memory through its single write port, and an erase blanks every cell
// from the cursor to the end of the screen. After reset a clearing pass writes
// every cell once, during which full stays high.
module ansi_text_console_engine #(
  parameter int COLUMNS   = 80,
  parameter int LINES     = 25,
  parameter int ESC_LIMIT = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  atce_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output atce_pkg::res_item_t out_item
);

  import atce_pkg::*;

  op_t       front_op;
  op_t       back_op;
  logic      in_valid;
  logic      op_full;
  logic      op_empty;
  logic      op_pop;
  logic      clearing;
  res_item_t res_item;
  logic      res_push;
  logic      res_full;

  assign full     = op_full || clearing;
  assign in_valid = push && !full;

  // Parser front end.
  atce_front #(
    .ESC_LIMIT (ESC_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .op_item  (front_op)
  );

  // Queue between parser and screen engine.
  atce_queue #(
    .item_t (op_t),
    .DEPTH  (4)
  ) u_op_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_op),
    .full      (op_full),
    .pop       (op_pop),
    .pop_item  (back_op),
    .empty     (op_empty)
  );

  // Screen engine.
  atce_back #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_item  (back_op),
    .op_empty (op_empty),
    .op_pop   (op_pop),
    .res_item (res_item),
    .res_push (res_push),
    .res_full (res_full),
    .clearing (clearing)
  );

  // Result queue toward the consumer.
  atce_queue #(
    .item_t (res_item_t),
    .DEPTH  (2)
  ) u_res_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_item (res_item),
    .full      (res_full),
    .pop       (pop),
    .pop_item  (out_item),
    .empty     (empty)
  );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the text console engine with a built-in screen predictor.
module testbench;
  import atce_pkg::*;

  // Screen geometry and escape limits used by both the block and the predictor.
  localparam int COLUMNS     = 80;
  localparam int LINES       = 25;
  localparam int ESC_LIMIT   = 20;
  localparam int CELLS       = COLUMNS * LINES;
  localparam int INDEX_MAX   = (1 << IDX_W) - 1;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int RANDOM_ITEMS = 300;
  localparam int LONG_HOLD   = 3000;
  localparam int DRAIN_CYCLES = 50;

  // Byte values that the stimulus needs beyond the package codes.
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_FF     = 8'hFF;
  localparam logic [7:0] PRINT_LO    = 8'h20;
  localparam logic [7:0] PRINT_HI    = 8'h7E;
  localparam logic [7:0] FINAL_OTHER = 8'h4B;

  // Select Graphic Rendition parameter codes.
  localparam int SGR_RESET     = 0;
  localparam int SGR_FG        = 30;
  localparam int SGR_FG_CLEAR  = 38;
  localparam int SGR_BG        = 40;
  localparam int SGR_BG_CLEAR  = 48;
  localparam int SGR_FG_BRIGHT = 90;
  localparam int SGR_BG_BRIGHT = 100;
  localparam int SGR_MAX_VALUE = 255;

  typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_PARAMS} esc_phase_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_item = '0;
  res_item_t out_item;

  ansi_text_console_engine #(
    .COLUMNS(COLUMNS),
    .LINES(LINES),
    .ESC_LIMIT(ESC_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_item(in_item),
    .empty(empty),
    .pop(pop),
    .out_item(out_item)
  );

  // Predicted console state.
  logic [7:0]  scr_char [CELLS];
  logic [7:0]  scr_attr [CELLS];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  cur_attr;
  logic [7:0]  sgr_attr;
  esc_phase_t  phase;
  int unsigned param_bytes;
  int unsigned param_acc;

  // Stimulus, expectations and bookkeeping.
  in_item_t    items_to_send[$];
  res_item_t   screen_reports[$];
  int unsigned errors = 0;
  int unsigned reports_checked = 0;
  int unsigned cycle_count = 0;
  logic        item_taken = 1'b0;
  logic        result_taken = 1'b0;
  int unsigned send_wait = 0;
  int unsigned pop_wait = 0;
  int unsigned hold_cycles = 0;
  logic        send_calm = 1'b0;
  logic        pop_calm = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Reset is held low at the start and released on a falling edge.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic void console_reset();
    for (int i = 0; i < CELLS; i++) begin
      scr_char[i] = BLANK_CHAR;
      scr_attr[i] = ATTR_RESET;
    end
    cur_row = 0;
    cur_col = 0;
    cur_attr = ATTR_RESET;
    sgr_attr = ATTR_RESET;
    phase = PH_TEXT;
    param_bytes = 0;
    param_acc = 0;
  endfunction

  // Colour index with the red and blue bits exchanged.
  function automatic logic [2:0] swap_rb(logic [2:0] c);
    return {c[0], c[1], c[2]};
  endfunction

  function automatic void sgr_update(int unsigned v);
    if (v == SGR_RESET) begin
      sgr_attr = ATTR_SGR0;
    end else if (v == SGR_FG_CLEAR) begin
      sgr_attr[3:0] = 4'h0;
    end else if (v == SGR_BG_CLEAR) begin
      sgr_attr[7:4] = 4'h0;
    end else if (v >= SGR_FG && v <= SGR_FG + 7) begin
      sgr_attr[3:0] = {1'b0, swap_rb(3'(v - SGR_FG))};
    end else if (v >= SGR_BG && v <= SGR_BG + 7) begin
      sgr_attr[7:4] = {1'b0, swap_rb(3'(v - SGR_BG))};
    end else if (v >= SGR_FG_BRIGHT && v <= SGR_FG_BRIGHT + 7) begin
      sgr_attr[3:0] = {1'b1, swap_rb(3'(v - SGR_FG_BRIGHT))};
    end else if (v >= SGR_BG_BRIGHT && v <= SGR_BG_BRIGHT + 7) begin
      sgr_attr[7:4] = {1'b1, swap_rb(3'(v - SGR_BG_BRIGHT))};
    end
  endfunction

  function automatic void blank_from(int unsigned start);
    for (int unsigned j = start; j < CELLS; j++) begin
      scr_char[j] = BLANK_CHAR;
      scr_attr[j] = cur_attr;
    end
  endfunction

  // Text output: line wrap, scroll at the bottom, then the character itself.
  function automatic void put_text(logic [7:0] b);
    int unsigned idx;
    if (b == CHAR_LF || cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= LINES) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        scr_char[i] = scr_char[i + COLUMNS];
        scr_attr[i] = scr_attr[i + COLUMNS];
      end
      cur_row = LINES - 1;
      blank_from(CELLS - COLUMNS);
    end
    if (b != CHAR_LF) begin
      idx = cur_row * COLUMNS + cur_col;
      if (idx < CELLS) begin
        scr_char[idx] = b;
        scr_attr[idx] = cur_attr;
      end
      cur_col++;
    end
  endfunction

  // One byte through the escape parser.
  function automatic void feed_byte(logic [7:0] b);
    logic is_digit;
    is_digit = (b >= CHAR_ZERO && b <= CHAR_NINE);
    if (b == CHAR_NUL) return;
    case (phase)
      PH_ESC: begin
        if (b == CHAR_LBRK) begin
          phase = PH_PARAMS;
          param_bytes = 0;
          param_acc = 0;
          sgr_attr = cur_attr;
        end else begin
          phase = PH_TEXT;
        end
      end
      PH_PARAMS: begin
        if (!is_digit && b != CHAR_SEMI) begin
          if (b == CHAR_SGR) begin
            sgr_update(param_acc);
            cur_attr = sgr_attr;
          end else if (b == CHAR_ERASE) begin
            blank_from(cur_row * COLUMNS + cur_col);
          end
          phase = PH_TEXT;
          param_bytes = 0;
          param_acc = 0;
        end else if (param_bytes >= ESC_LIMIT) begin
          phase = PH_TEXT;
          param_bytes = 0;
          param_acc = 0;
        end else begin
          param_bytes++;
          if (is_digit) begin
            param_acc = param_acc * 10 + (b - CHAR_ZERO);
            if (param_acc > SGR_MAX_VALUE) param_acc = SGR_MAX_VALUE;
          end else begin
            sgr_update(param_acc);
            param_acc = 0;
          end
        end
      end
      default: begin
        if (b == CHAR_ESC) phase = PH_ESC;
        else put_text(b);
      end
    endcase
  endfunction

  // Applies one item and returns the cell and cursor report it should produce.
  function automatic res_item_t console_update(in_item_t it);
    res_item_t r;
    r = '0;
    if (it.command == CMD_PUT) begin
      feed_byte(it.byte_in);
    end else if (it.cell_index < CELLS) begin
      r.cell_char = scr_char[it.cell_index];
      r.cell_attr = scr_attr[it.cell_index];
    end
    r.cursor_row = ROW_W'(cur_row);
    r.cursor_col = COL_W'(cur_col);
    r.attribute = cur_attr;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Stimulus builders.
  task automatic queue_put(logic [7:0] b);
    in_item_t it;
    it.command = CMD_PUT;
    it.byte_in = b;
    it.cell_index = IDX_W'($urandom_range(0, INDEX_MAX));
    items_to_send.push_back(it);
  endtask

  task automatic queue_read(int unsigned idx);
    in_item_t it;
    it.command = CMD_READ;
    it.byte_in = 8'($urandom_range(0, 255));
    it.cell_index = IDX_W'(idx);
    items_to_send.push_back(it);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_put(s[i]);
  endtask

  task automatic queue_csi(string params, logic [7:0] final_byte);
    queue_put(CHAR_ESC);
    queue_put(CHAR_LBRK);
    queue_text(params);
    queue_put(final_byte);
  endtask

  function automatic logic [7:0] printable();
    return 8'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  // A list of SGR values, mostly meaningful ones, some empty or oversized.
  function automatic string sgr_params(int unsigned n);
    string s;
    int unsigned v;
    s = "";
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 6))
        0: v = SGR_RESET;
        1: v = $urandom_range(SGR_FG, SGR_FG + 7);
        2: v = $urandom_range(SGR_BG, SGR_BG + 7);
        3: v = $urandom_range(SGR_FG_BRIGHT, SGR_FG_BRIGHT + 7);
        4: v = $urandom_range(SGR_BG_BRIGHT, SGR_BG_BRIGHT + 7);
        5: v = $urandom_range(0, 1) ? SGR_FG_CLEAR : SGR_BG_CLEAR;
        default: v = $urandom_range(0, 999);
      endcase
      if (k != 0) s = {s, ";"};
      if ($urandom_range(0, 7) != 0) s = {s, $sformatf("%0d", v)};
    end
    return s;
  endfunction

  // Record each accepted item and check each accepted result on the rising edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    item_taken <= rst_n && push && !full;
    result_taken <= rst_n && pop && !empty;
    if (rst_n && pop && !empty) begin
      if (screen_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
      end else begin
        res_item_t want;
        want = screen_reports.pop_front();
        check_field("cell_char", want.cell_char, out_item.cell_char);
        check_field("cell_attr", want.cell_attr, out_item.cell_attr);
        check_field("cursor_row", want.cursor_row, out_item.cursor_row);
        check_field("cursor_col", want.cursor_col, out_item.cursor_col);
        check_field("attribute", want.attribute, out_item.attribute);
      end
      reports_checked++;
    end
    if (rst_n && push && !full) screen_reports.push_back(console_update(in_item));
  end

  // Sender: presents queued items after a random gap, with calm stretches.
  always @(negedge clk) begin
    if (rst_n) begin
      if (item_taken) begin
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 12);
      end
      if (!push || item_taken) begin
        if (send_wait > 0) begin
          send_wait--;
          push <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          in_item <= items_to_send.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: random pop gaps, and twice a long hold-off that backs the block up.
  always @(negedge clk) begin
    if (rst_n) begin
      if (result_taken) begin
        if ($urandom_range(0, 29) == 0) pop_calm = !pop_calm;
        pop_wait = pop_calm ? 0 : $urandom_range(0, 12);
        if (reports_checked == 20 || reports_checked == 180) hold_cycles = LONG_HOLD;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else if (pop_wait > 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned stop_at;
    int unsigned pick;
    logic        row_fill_done;
    console_reset();
    row_fill_done = 1'b0;

    // Directed: reset contents, an out-of-range read, zero byte, SGR, aborted
    // and unknown sequences, newline and erase.
    queue_read(0);
    queue_read(CELLS - 1);
    queue_read(INDEX_MAX);
    queue_put(CHAR_NUL);
    queue_text("A");
    queue_put(CHAR_FF);
    queue_csi("103;999", CHAR_SGR);
    queue_put(CHAR_ESC);
    queue_text("x");
    queue_csi("", FINAL_OTHER);
    queue_put(CHAR_LF);
    queue_csi("", CHAR_ERASE);
    queue_read(1);
    stop_at = items_to_send.size() + RANDOM_ITEMS;

    // Random: mostly well-formed text, newlines and sequences, some noise.
    while (items_to_send.size() < stop_at) begin
      if (!row_fill_done && items_to_send.size() > stop_at - RANDOM_ITEMS / 2) begin
        // Fill one row exactly, then erase from the full-row position.
        row_fill_done = 1'b1;
        queue_put(CHAR_LF);
        repeat (COLUMNS) queue_put(printable());
        queue_csi("", CHAR_ERASE);
      end
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        repeat ($urandom_range(1, 12)) queue_put(printable());
      end else if (pick < 40) begin
        repeat ($urandom_range(1, 3)) queue_put(CHAR_LF);
      end else if (pick < 60) begin
        queue_csi(sgr_params($urandom_range(0, 4)), CHAR_SGR);
      end else if (pick < 65) begin
        queue_csi(sgr_params($urandom_range(0, 1)), CHAR_ERASE);
      end else if (pick < 70) begin
        // Parameter lists around the length limit.
        string s;
        s = "";
        repeat ($urandom_range(ESC_LIMIT - 1, ESC_LIMIT + 4)) begin
          if ($urandom_range(0, 10) == 0) s = {s, ";"};
          else s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
        queue_csi(s, CHAR_SGR);
      end else if (pick < 75) begin
        if ($urandom_range(0, 1)) begin
          queue_put(CHAR_ESC);
          queue_put(8'($urandom_range(0, 255)));
        end else begin
          queue_csi(sgr_params($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
        end
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 4) == 0) queue_read($urandom_range(0, INDEX_MAX));
          else queue_read($urandom_range(0, CELLS - 1));
        end
      end else if (pick < 92) begin
        queue_put(8'($urandom_range(0, 255)));
      end else begin
        // Several short lines, which scroll the screen once the bottom is reached.
        repeat ($urandom_range(3, 6)) begin
          repeat ($urandom_range(0, 6)) queue_put(printable());
          queue_put(CHAR_LF);
        end
      end
    end

    fork
      begin
        @(posedge rst_n);
        while (items_to_send.size() != 0 || push) @(posedge clk);
        while (screen_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timed out with %0d results outstanding", $time, screen_reports.size());
      end
    join_any

    if (cycle_count >= CYCLE_LIMIT || errors != 0) begin
      $display("Verification failed");
    end else begin
      $display("Verification passed");
    end
    $finish;
  end

endmodule

### files.f
hdl/atce_pkg.sv
hdl/atce_queue.sv
hdl/atce_front.sv
hdl/atce_back.sv
hdl/ansi_text_console_engine.sv
tb/sv/testbench.sv
